### design/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// shared widths, constants, the sector table and the divider stage word
// ----------------------------------------------------------------------------
package svpwm_pkg;

  localparam int VW = 16;
  localparam int FB = 15;
  localparam int DW = FB + 1;
  localparam int WW = 36;
  localparam int RW = 38;
  localparam int NSTEP = FB + 1;
  localparam int SQRT3_Q16 = 113512;
  localparam int THREE_Q16 = 196608;

  typedef struct packed {
    logic [2:0][RW-1:0] r;
    logic [2:0][DW-1:0] q;
    logic [RW-1:0]      den;
    logic [2:0]         sector;
    logic               ok;
  } div_t;

  function automatic logic [2:0] code_to_sector(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      3'd0: s = 3'd1;
      3'd1: s = 3'd4;
      3'd2: s = 3'd6;
      3'd3: s = 3'd5;
      3'd4: s = 3'd2;
      3'd5: s = 3'd3;
      3'd6: s = 3'd1;
      default: s = 3'd1;
    endcase
    return s;
  endfunction

endpackage

### design/svpwm_front.sv
// ----------------------------------------------------------------------------
// svpwm_front
// three stages: projections, sector and dwell times, edge time sums
// ----------------------------------------------------------------------------
module svpwm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [svpwm_pkg::VW-1:0]     alpha_voltage,
  input  logic [svpwm_pkg::VW-1:0]     beta_voltage,
  input  logic [svpwm_pkg::VW-1:0]     bus_voltage,
  input  logic [15:0]                  switching_period,
  output logic                         out_valid,
  output svpwm_pkg::div_t              out_word
);

  localparam int WW = svpwm_pkg::WW;
  localparam int RW = svpwm_pkg::RW;
  localparam int VW = svpwm_pkg::VW;
  localparam logic signed [WW-1:0] K3 = WW'(svpwm_pkg::THREE_Q16);
  localparam logic signed [WW-1:0] KS = WW'(svpwm_pkg::SQRT3_Q16);

  // stage 1
  logic                 v1, ok1;
  logic signed [WW-1:0] pa, pb;
  logic [VW-1:0]        vdc1;
  logic signed [WW-1:0] ax, bx;

  assign ax = {{(WW-VW){alpha_voltage[VW-1]}}, alpha_voltage};
  assign bx = {{(WW-VW){beta_voltage[VW-1]}}, beta_voltage};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      pa   <= ax * K3;
      pb   <= bx * KS;
      vdc1 <= bus_voltage;
      ok1  <= (switching_period != 16'd0) && (bus_voltage != '0);
    end
  end

  // stage 2
  logic signed [WW-1:0] w1, w2, w3;
  logic [2:0]           code, sec_c;
  logic [RW-1:0]        n1_c, n2_c;
  logic                 v2, ok2;
  logic [2:0]           sec2;
  logic [RW-1:0]        n1, n2, d2;

  function automatic logic [RW-1:0] nonneg(input logic signed [WW-1:0] v);
    return (v > 0) ? RW'(unsigned'(v)) : '0;
  endfunction

  always_comb begin
    w1 = pb <<< 1;
    w2 = pa - pb;
    w3 = -pa - pb;
    code = {w1 > 0, w2 > 0, w3 > 0};
    sec_c = svpwm_pkg::code_to_sector(code);
    case (sec_c)
      3'd1: begin n1_c = nonneg(w2);  n2_c = nonneg(w1);  end
      3'd2: begin n1_c = nonneg(-w3); n2_c = nonneg(-w2); end
      3'd3: begin n1_c = nonneg(w1);  n2_c = nonneg(w3);  end
      3'd4: begin n1_c = nonneg(-w2); n2_c = nonneg(-w1); end
      3'd5: begin n1_c = nonneg(w3);  n2_c = nonneg(w2);  end
      default: begin n1_c = nonneg(-w1); n2_c = nonneg(-w3); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      sec2 <= sec_c;
      n1   <= n1_c;
      n2   <= n2_c;
      d2   <= {(RW-VW-17)'(0), vdc1, 17'd0};
      ok2  <= ok1;
    end
  end

  // stage 3
  logic [RW-1:0] s, dd, h, full, one1, one2, xa, xb, xc;

  always_comb begin
    s    = n1 + n2;
    dd   = (s > d2) ? s : d2;
    h    = dd - s;
    full = (s << 1) + h;
    one1 = (n1 << 1) + h;
    one2 = (n2 << 1) + h;
    case (sec2)
      3'd1: begin xa = full; xb = one2; xc = h;    end
      3'd2: begin xa = one1; xb = full; xc = h;    end
      3'd3: begin xa = h;    xb = full; xc = one2; end
      3'd4: begin xa = h;    xb = one1; xc = full; end
      3'd5: begin xa = one2; xb = h;    xc = full; end
      default: begin xa = full; xb = h; xc = one1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      out_word.r[0]   <= xa;
      out_word.r[1]   <= xb;
      out_word.r[2]   <= xc;
      out_word.q      <= '0;
      out_word.den    <= dd << 1;
      out_word.sector <= sec2;
      out_word.ok     <= ok2;
    end
  end

endmodule

### design/svpwm_div_stage.sv
// ----------------------------------------------------------------------------
// svpwm_div_stage
// one restoring division step for the three phase lanes
// ----------------------------------------------------------------------------
module svpwm_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            shift,
  input  logic            in_valid,
  input  svpwm_pkg::div_t in_word,
  output logic            out_valid,
  output svpwm_pkg::div_t out_word
);

  localparam int RW = svpwm_pkg::RW;
  localparam int DW = svpwm_pkg::DW;

  svpwm_pkg::div_t nxt;
  logic [RW-1:0]   t;
  logic            ge;

  always_comb begin
    nxt = in_word;
    for (int i = 0; i < 3; i++) begin
      t  = shift ? (in_word.r[i] << 1) : in_word.r[i];
      ge = (t >= in_word.den);
      nxt.r[i] = ge ? (t - in_word.den) : t;
      nxt.q[i] = {in_word.q[i][DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_word <= nxt;
    end
  end

endmodule

### design/space_vector_pwm_duty_core.sv
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_core
// seven-segment space vector pwm duties and sector from an alpha/beta
// reference and the bus voltage
//
// channel  dir  contents
// s_axis   in   alpha, beta, bus voltage
// m_axis   out  duty a, b, c, sector, ok
// cfg      in   switching period
//
// one word per cycle while the output is not stalled; 3 front stages and 16 divider steps
// set the depth.
// rst clears all valid bits and sets the period to 1.
// a stalled output freezes the whole pipeline; s_tready follows it.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // alpha_voltage, beta_voltage, bus_voltage
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata   // duty_a, duty_b, duty_c, sector, ok, zero pad
);

  localparam int NS = svpwm_pkg::NSTEP;

  logic [15:0] switching_period;
  logic        en;

  always_ff @(posedge clk) begin
    if (rst) begin
      switching_period <= 16'd1;
    end else if (cfg_wen) begin
      switching_period <= cfg_wdata;
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic            v [NS+1];
  svpwm_pkg::div_t w [NS+1];

  svpwm_front u_front (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (s_tvalid),
    .alpha_voltage    (s_tdata[15:0]),
    .beta_voltage     (s_tdata[31:16]),
    .bus_voltage      (s_tdata[47:32]),
    .switching_period (switching_period),
    .out_valid        (v[0]),
    .out_word         (w[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_div
    svpwm_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .shift     (g != 0),
      .in_valid  (v[g]),
      .in_word   (w[g]),
      .out_valid (v[g+1]),
      .out_word  (w[g+1])
    );
  end

  svpwm_pkg::div_t fin;
  assign fin      = w[NS];
  assign m_tvalid = v[NS];
  assign m_tdata  = fin.ok ? {4'd0, 1'b1, fin.sector, fin.q[2], fin.q[1], fin.q[0]} : '0;

  a_ready : assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready)) else $error("ready mismatch");
  a_sector : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[51] |-> m_tdata[50:48] != 3'd0 && m_tdata[50:48] != 3'd7)
    else $error("bad sector");
  a_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("stall lost word");

endmodule

### bench/space_vector_pwm_duty_core_tb.sv
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_core_tb
// self-checking bench for the space vector pwm duty core: a directed table,
// then random references over several switching period settings, with
// random idle gaps on the input and random stalls on the output
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_core_tb;

  // fields from the lowest bit up: duty_a, duty_b, duty_c, sector, ok
  typedef struct packed {
    logic        ok;
    logic [2:0]  sector;
    logic [15:0] duty_c;
    logic [15:0] duty_b;
    logic [15:0] duty_a;
  } duty_rec_t;

  typedef struct {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [15:0]        bus;
    bit                 typed;
    duty_rec_t          duties;
  } ref_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // alpha_voltage, beta_voltage, bus_voltage
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;       // duty_a, duty_b, duty_c, sector, ok, zero pad

  logic [15:0] period_reg = 16'd1;
  duty_rec_t   duty_queue[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          no_gaps = 1'b0;
  int          stall_left = 0;

  space_vector_pwm_duty_core DUT (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint pos(longint v);
    return v > 0 ? v : 0;
  endfunction

  function automatic duty_rec_t calc_duties(logic signed [15:0] al,
                                            logic signed [15:0] be,
                                            logic [15:0] vb);
    longint w1, w2, w3, n1, n2, s, d, h, full, one1, one2, xa, xb, xc;
    logic [2:0] code;
    duty_rec_t r;
    r = '0;
    if (period_reg == 0 || vb == 0) return r;
    w1 = 2 * longint'(svpwm_pkg::SQRT3_Q16) * longint'(be);
    w2 = longint'(svpwm_pkg::THREE_Q16) * longint'(al)
         - longint'(svpwm_pkg::SQRT3_Q16) * longint'(be);
    w3 = -longint'(svpwm_pkg::THREE_Q16) * longint'(al)
         - longint'(svpwm_pkg::SQRT3_Q16) * longint'(be);
    code = {w1 > 0, w2 > 0, w3 > 0};
    case (code)
      3'b100: r.sector = 3'd2;
      3'b101: r.sector = 3'd3;
      3'b001: r.sector = 3'd4;
      3'b011: r.sector = 3'd5;
      3'b010: r.sector = 3'd6;
      default: r.sector = 3'd1;
    endcase
    case (r.sector)
      3'd1: begin n1 = pos(w2);  n2 = pos(w1);  end
      3'd2: begin n1 = pos(-w3); n2 = pos(-w2); end
      3'd3: begin n1 = pos(w1);  n2 = pos(w3);  end
      3'd4: begin n1 = pos(-w2); n2 = pos(-w1); end
      3'd5: begin n1 = pos(w3);  n2 = pos(w2);  end
      default: begin n1 = pos(-w1); n2 = pos(-w3); end
    endcase
    d = longint'(vb) << 17;
    s = n1 + n2;
    if (s > d) d = s;
    h = d - s;
    full = 2 * s + h;
    one1 = 2 * n1 + h;
    one2 = 2 * n2 + h;
    case (r.sector)
      3'd1: begin xa = full; xb = one2; xc = h;    end
      3'd2: begin xa = one1; xb = full; xc = h;    end
      3'd3: begin xa = h;    xb = full; xc = one2; end
      3'd4: begin xa = h;    xb = one1; xc = full; end
      3'd5: begin xa = one2; xb = h;    xc = full; end
      default: begin xa = full; xb = h; xc = one1; end
    endcase
    r.duty_a = 16'((xa << 15) / (2 * d));
    r.duty_b = 16'((xb << 15) / (2 * d));
    r.duty_c = 16'((xc << 15) / (2 * d));
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(logic signed [15:0] al, logic signed [15:0] be,
                           logic [15:0] vb, bit typed, duty_rec_t exp_rec);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {vb, be, al};
    do @(posedge clk); while (!s_tready);
    duty_queue.push_back(typed ? exp_rec : calc_duties(al, be, vb));
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (duty_queue.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_period(logic [15:0] v);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    period_reg = v;
  endtask

  task automatic send_random(int count);
    logic signed [15:0] al, be;
    logic [15:0] vb;
    int sel, lim;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      vb = (sel < 60) ? 16'($urandom_range(1, 4000)) : 16'($urandom);
      if (sel < 5) vb = 0;
      if (sel < 75) begin
        // reference sized near the linear limit so both regions are hit
        lim = int'(vb);
        if (lim > 32767) lim = 32767;
        al = 16'($urandom_range(0, 2 * lim) - lim);
        be = 16'($urandom_range(0, 2 * lim) - lim);
      end else begin
        al = 16'($urandom);
        be = 16'($urandom);
      end
      send_word(al, be, vb, 1'b0, '0);
    end
  endtask

  // output side: random stalls, with stall-free stretches
  always @(posedge clk) begin
    duty_rec_t got, want;
    if (m_tvalid && m_tready) begin
      got = duty_rec_t'(m_tdata[51:0]);
      if (duty_queue.size() == 0) begin
        $error("unexpected word %h", m_tdata);
        mismatches++;
      end else begin
        want = duty_queue.pop_front();
        if (got.duty_a !== want.duty_a) begin
          $error("duty_a exp %0d got %0d", want.duty_a, got.duty_a); mismatches++;
        end
        if (got.duty_b !== want.duty_b) begin
          $error("duty_b exp %0d got %0d", want.duty_b, got.duty_b); mismatches++;
        end
        if (got.duty_c !== want.duty_c) begin
          $error("duty_c exp %0d got %0d", want.duty_c, got.duty_c); mismatches++;
        end
        if (got.sector !== want.sector) begin
          $error("sector exp %0d got %0d", want.sector, got.sector); mismatches++;
        end
        if (got.ok !== want.ok) begin
          $error("ok exp %0d got %0d", want.ok, got.ok); mismatches++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!no_gaps && $urandom_range(0, 99) < 30)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(1, 3);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst && ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (!s_tvalid && duty_queue.size() == 0)))
      idle_cycles <= 0;
    else if (!rst)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 2000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    ref_row_t rows[$];
    duty_rec_t half, zero;
    half = '{duty_a: 16'd16384, duty_b: 16'd16384, duty_c: 16'd16384,
             sector: 3'd1, ok: 1'b1};
    zero = '0;
    rows = '{
      '{0, 0, 100, 1, half},
      '{0, 0, 65535, 1, half},
      '{1000, 1000, 0, 1, zero},
      '{-32768, -32768, 0, 1, zero},
      '{0, 0, 1, 1, half},
      '{1000, 200, 2000, 0, zero},
      '{0, 1000, 2000, 0, zero},
      '{-1000, 200, 2000, 0, zero},
      '{-1000, -200, 2000, 0, zero},
      '{0, -1000, 2000, 0, zero},
      '{1000, -200, 2000, 0, zero},
      '{32767, 0, 1, 0, zero},
      '{-32768, 0, 1, 0, zero},
      '{0, 32767, 65535, 0, zero},
      '{0, -32768, 65535, 0, zero},
      '{32767, 32767, 65535, 0, zero},
      '{-32768, -32768, 65535, 0, zero},
      '{32767, -32768, 40000, 0, zero},
      '{-32768, 32767, 40000, 0, zero},
      '{1, 0, 1, 0, zero},
      '{-1, -1, 1, 0, zero},
      '{20000, 11547, 23094, 0, zero},
      '{5000, 0, 65535, 0, zero}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    no_gaps = 1'b1;
    foreach (rows[i])
      send_word(rows[i].alpha, rows[i].beta, rows[i].bus, rows[i].typed,
                rows[i].duties);
    no_gaps = 1'b0;
    send_random(200);
    drain();
    send_random(50);
    write_period(16'hFFFF);
    no_gaps = 1'b1;
    send_random(100);
    no_gaps = 1'b0;
    send_random(100);
    write_period(16'd0);
    send_word(0, 0, 100, 1'b1, zero);
    send_random(60);
    write_period(16'($urandom_range(1, 65534)));
    send_random(120);
    write_period(16'd1);
    send_random(100);
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
design/svpwm_pkg.sv
design/svpwm_front.sv
design/svpwm_div_stage.sv
design/space_vector_pwm_duty_core.sv
bench/space_vector_pwm_duty_core_tb.sv
